### rtl/fqs_pkg.sv
package fqs_pkg;

	typedef logic signed [31:0] w_t;
	typedef logic signed [15:0] c_t;

	typedef enum logic [1:0] {
		SEL_CALC = 2'd0,
		SEL_Q1   = 2'd1,
		SEL_Q2   = 2'd2
	} sel_t;

	typedef struct packed {
		logic       valid;
		sel_t       sel;
		logic       neg;
		c_t [3:0]   a;
		c_t [3:0]   b;
	} ctx_t;

	typedef struct packed {
		w_t f1;
		w_t u;
		w_t f2a;
		w_t f2b;
	} fold_t;

	typedef struct packed {
		ctx_t      ctx;
		fold_t     fold;
		w_t [1:0]  sq;
		w_t        halfy;
	} pipe_t;

	localparam logic [16:0] T_ONE = 17'd65536;

	localparam w_t K_A0   = 32'sd18287165;
	localparam w_t K_A1   = 32'sd7994964;
	localparam w_t K_A2   = 32'sd1515521;
	localparam w_t K_S4   = 32'sd740;
	localparam w_t K_S3   = -32'sd26631;
	localparam w_t K_S2   = 32'sd559241;
	localparam w_t K_S1   = -32'sd5592405;
	localparam w_t K_16   = 32'sd268435456;
	localparam w_t K_9    = 32'sd150994944;
	localparam w_t K_4    = 32'sd67108864;
	localparam w_t K_1P5  = 32'sd25165824;
	localparam w_t K_HALF = 32'sd8388608;
	localparam w_t K_ONE  = 32'sd16777216;
	localparam w_t W_MAX  = 32'sh7fffffff;
	localparam w_t W_MIN  = -32'sh7fffffff - 32'sd1;

	function automatic w_t wsat(input logic signed [63:0] v);
		if (v > 64'(W_MAX)) begin
			return W_MAX;
		end else if (v < 64'(W_MIN)) begin
			return W_MIN;
		end
		return v[31:0];
	endfunction

	function automatic w_t wadd(input w_t a, input w_t b);
		logic signed [63:0] s;
		s = 64'(a) + 64'(b);
		return wsat(s);
	endfunction

	function automatic w_t wsub(input w_t a, input w_t b);
		logic signed [63:0] s;
		s = 64'(a) - 64'(b);
		return wsat(s);
	endfunction

	function automatic w_t wmul(input w_t a, input w_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + 64'sd8388608;
		return wsat(p >>> 24);
	endfunction

endpackage

### rtl/fqs_front.sv
module fqs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  fqs_pkg::c_t [3:0]      q1,
	input  fqs_pkg::c_t [3:0]      q2,
	input  logic [16:0]            t_frac,
	output fqs_pkg::pipe_t         p_s2
);

	fqs_pkg::ctx_t      ctx_d, ctx_s1;
	fqs_pkg::fold_t     fold_d, fold_s1;
	fqs_pkg::w_t        prod_s1 [4];
	fqs_pkg::pipe_t     p_d;
	logic [16:0]        tf;
	fqs_pkg::w_t        t, f2b0, u;
	logic signed [33:0] dot, absd, rsh;

	always_comb begin
		tf = (t_frac > fqs_pkg::T_ONE) ? fqs_pkg::T_ONE : t_frac;
		ctx_d.valid = in_valid;
		ctx_d.neg   = 1'b0;
		ctx_d.a     = q1;
		ctx_d.b     = q2;
		if (tf == 17'd0 || q1 == q2) begin
			ctx_d.sel = fqs_pkg::SEL_Q1;
		end else if (tf == fqs_pkg::T_ONE) begin
			ctx_d.sel = fqs_pkg::SEL_Q2;
		end else begin
			ctx_d.sel = fqs_pkg::SEL_CALC;
		end
		t    = $signed({7'd0, tf, 8'd0});
		f2b0 = t - fqs_pkg::K_HALF;
		u    = f2b0[31] ? -f2b0 : f2b0;
		fold_d.f2a = u - f2b0;
		fold_d.f2b = f2b0 + u;
		fold_d.u   = u + u;
		fold_d.f1  = fqs_pkg::K_ONE - (u + u);
	end

	always_comb begin
		dot = 34'(prod_s1[0]) + 34'(prod_s1[1]) + 34'(prod_s1[2]) + 34'(prod_s1[3]);
		absd = dot[33] ? -dot : dot;
		rsh  = (absd + 34'sd8) >>> 4;
		p_d.ctx       = ctx_s1;
		p_d.ctx.neg   = dot[33];
		p_d.fold      = fold_s1;
		p_d.halfy     = fqs_pkg::K_ONE + 32'(rsh);
		p_d.sq[0]     = fqs_pkg::wmul(fold_s1.f1, fold_s1.f1);
		p_d.sq[1]     = fqs_pkg::wmul(fold_s1.u, fold_s1.u);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s1 <= '0;
			p_s2   <= '0;
		end else if (en) begin
			ctx_s1 <= ctx_d;
			p_s2   <= p_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1 <= fold_d;
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= 32'($signed(q1[i])) * 32'($signed(q2[i]));
			end
		end
	end

endmodule

### rtl/fqs_secant.sv
module fqs_secant (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fqs_pkg::pipe_t  p_s2,
	output fqs_pkg::pipe_t  p_s9,
	output fqs_pkg::w_t     sec_s9,
	output fqs_pkg::w_t     vers_s9,
	output fqs_pkg::w_t     r2sh_s9
);

	fqs_pkg::pipe_t p_s3, p_s4, p_s5, p_s6, p_s7, p_s8;
	fqs_pkg::w_t    x_s3, sec0_s4, sec0_s5, m_s5, sec0_s6, y_s6, sec_s7, sec_s8, vers_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s3 <= '0;
			p_s4 <= '0;
			p_s5 <= '0;
			p_s6 <= '0;
			p_s7 <= '0;
			p_s8 <= '0;
			p_s9 <= '0;
		end else if (en) begin
			p_s3 <= p_s2;
			p_s4 <= p_s3;
			p_s5 <= p_s4;
			p_s6 <= p_s5;
			p_s7 <= p_s6;
			p_s8 <= p_s7;
			p_s9 <= p_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= fqs_pkg::wsub(fqs_pkg::K_A1, fqs_pkg::wmul(fqs_pkg::K_A2, p_s2.halfy));
			sec0_s4 <= fqs_pkg::wsub(fqs_pkg::K_A0, fqs_pkg::wmul(x_s3, p_s3.halfy));
			sec0_s5 <= sec0_s4;
			m_s5    <= fqs_pkg::wmul(p_s4.halfy, sec0_s4);
			sec0_s6 <= sec0_s5;
			y_s6    <= fqs_pkg::wsub(fqs_pkg::K_1P5, fqs_pkg::wmul(m_s5, sec0_s5));
			sec_s7  <= fqs_pkg::wmul(sec0_s6, y_s6);
			sec_s8  <= sec_s7;
			vers_s8 <= fqs_pkg::wsub(fqs_pkg::K_ONE, fqs_pkg::wmul(p_s7.halfy, sec_s7));
			sec_s9  <= sec_s8;
			vers_s9 <= vers_s8;
			r2sh_s9 <= fqs_pkg::wmul(fqs_pkg::K_S4, vers_s8);
		end
	end

endmodule

### rtl/fqs_series.sv
module fqs_series (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  fqs_pkg::pipe_t  p_s9,
	input  fqs_pkg::w_t     sec_s9,
	input  fqs_pkg::w_t     vers_s9,
	input  fqs_pkg::w_t     r2sh_s9,
	output fqs_pkg::ctx_t   ctx_s18,
	output fqs_pkg::w_t     alpha_s18,
	output fqs_pkg::w_t     beta_s18
);

	fqs_pkg::pipe_t p_s10, p_s11, p_s12, p_s13, p_s14, p_s15, p_s16, p_s17;
	fqs_pkg::w_t    sec_s10, sec_s11, sec_s12, sec_s13, sec_s14, sec_s15, sec_s16;
	fqs_pkg::w_t    vers_s10, vers_s11, vers_s12, vers_s13, vers_s14, vers_s15;
	fqs_pkg::w_t    r_s10 [2], m_s11 [2], r_s12 [2], m_s13 [2], r_s14 [2], m_s15 [2];
	fqs_pkg::w_t    r_s16 [2];
	fqs_pkg::w_t    x_s17, ga_s17, gb_s17, r1, al;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s10   <= '0;
			p_s11   <= '0;
			p_s12   <= '0;
			p_s13   <= '0;
			p_s14   <= '0;
			p_s15   <= '0;
			p_s16   <= '0;
			p_s17   <= '0;
			ctx_s18 <= '0;
		end else if (en) begin
			p_s10   <= p_s9;
			p_s11   <= p_s10;
			p_s12   <= p_s11;
			p_s13   <= p_s12;
			p_s14   <= p_s13;
			p_s15   <= p_s14;
			p_s16   <= p_s15;
			p_s17   <= p_s16;
			ctx_s18 <= p_s17.ctx;
		end
	end

	always_comb begin
		r1 = fqs_pkg::wmul(p_s17.fold.f1, x_s17);
		al = fqs_pkg::wadd(r1, ga_s17);
		if (p_s17.ctx.neg) begin
			al = fqs_pkg::wsub(32'sd0, al);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s10  <= sec_s9;
			sec_s11  <= sec_s10;
			sec_s12  <= sec_s11;
			sec_s13  <= sec_s12;
			sec_s14  <= sec_s13;
			sec_s15  <= sec_s14;
			sec_s16  <= sec_s15;
			vers_s10 <= vers_s9;
			vers_s11 <= vers_s10;
			vers_s12 <= vers_s11;
			vers_s13 <= vers_s12;
			vers_s14 <= vers_s13;
			vers_s15 <= vers_s14;
			for (int k = 0; k < 2; k++) begin
				r_s10[k] <= fqs_pkg::wadd(fqs_pkg::K_S3, fqs_pkg::wmul(
					fqs_pkg::wsub(p_s9.sq[k], fqs_pkg::K_16), r2sh_s9));
				m_s11[k] <= fqs_pkg::wmul(r_s10[k], fqs_pkg::wsub(p_s10.sq[k], fqs_pkg::K_9));
				r_s12[k] <= fqs_pkg::wadd(fqs_pkg::K_S2, fqs_pkg::wmul(m_s11[k], vers_s11));
				m_s13[k] <= fqs_pkg::wmul(r_s12[k], fqs_pkg::wsub(p_s12.sq[k], fqs_pkg::K_4));
				r_s14[k] <= fqs_pkg::wadd(fqs_pkg::K_S1, fqs_pkg::wmul(m_s13[k], vers_s13));
				m_s15[k] <= fqs_pkg::wmul(r_s14[k], fqs_pkg::wsub(p_s14.sq[k], fqs_pkg::K_ONE));
				r_s16[k] <= fqs_pkg::wadd(fqs_pkg::K_ONE, fqs_pkg::wmul(m_s15[k], vers_s15));
			end
			x_s17     <= fqs_pkg::wmul(r_s16[0], sec_s16);
			ga_s17    <= fqs_pkg::wmul(p_s16.fold.f2a, r_s16[1]);
			gb_s17    <= fqs_pkg::wmul(p_s16.fold.f2b, r_s16[1]);
			alpha_s18 <= al;
			beta_s18  <= fqs_pkg::wadd(r1, gb_s17);
		end
	end

endmodule

### rtl/fqs_combine.sv
module fqs_combine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  fqs_pkg::ctx_t       ctx_s18,
	input  fqs_pkg::w_t         alpha_s18,
	input  fqs_pkg::w_t         beta_s18,
	output logic                valid_s22,
	output fqs_pkg::c_t [3:0]   out_s22
);

	fqs_pkg::ctx_t      ctx_s19, ctx_s20, ctx_s21;
	fqs_pkg::w_t        v_s19 [4], v_s20 [4], v_s21 [4], sq_s20 [4];
	fqs_pkg::w_t        corr_s21, len;
	fqs_pkg::c_t [3:0]  res;
	logic [33:0]        acc;
	logic signed [63:0] prod;
	logic signed [63:0] rnd [4];

	always_comb begin
		acc = {2'b00, sq_s20[0]} + {2'b00, sq_s20[1]} + {2'b00, sq_s20[2]}
			+ {2'b00, sq_s20[3]};
		len = (acc > 34'(fqs_pkg::W_MAX)) ? fqs_pkg::W_MAX : acc[31:0];
	end

	always_comb begin
		prod = '0;
		for (int i = 0; i < 4; i++) begin
			prod   = 64'(v_s21[i]) * 64'(corr_s21);
			rnd[i] = (prod + 64'sd8589934592) >>> 34;
		end
		for (int i = 0; i < 4; i++) begin
			if (rnd[i] > 64'sd32767) begin
				res[i] = 16'sh7fff;
			end else if (rnd[i] < -64'sd32768) begin
				res[i] = -16'sh7fff - 16'sd1;
			end else begin
				res[i] = rnd[i][15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_s19   <= '0;
			ctx_s20   <= '0;
			ctx_s21   <= '0;
			valid_s22 <= 1'b0;
		end else if (en) begin
			ctx_s19   <= ctx_s18;
			ctx_s20   <= ctx_s19;
			ctx_s21   <= ctx_s20;
			valid_s22 <= ctx_s21.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				v_s19[i]  <= fqs_pkg::wadd(
					fqs_pkg::wmul(alpha_s18, $signed({{6{ctx_s18.a[i][15]}}, ctx_s18.a[i], 10'd0})),
					fqs_pkg::wmul(beta_s18, $signed({{6{ctx_s18.b[i][15]}}, ctx_s18.b[i], 10'd0})));
				v_s20[i]  <= v_s19[i];
				sq_s20[i] <= fqs_pkg::wmul(v_s19[i], v_s19[i]);
				v_s21[i]  <= v_s20[i];
			end
			corr_s21 <= fqs_pkg::wsub(fqs_pkg::K_1P5, fqs_pkg::wmul(fqs_pkg::K_HALF, len));
			case (ctx_s21.sel)
				fqs_pkg::SEL_Q1: out_s22 <= ctx_s21.a;
				fqs_pkg::SEL_Q2: out_s22 <= ctx_s21.b;
				default:         out_s22 <= res;
			endcase
		end
	end

endmodule

### rtl/fast_quaternion_slerp_top.sv
// Pipeline: 22 register stages, s1 to s22; m_tvalid rises when an item reaches the s22 register.
// Throughput: one item per cycle while the output is not stalled; each stage holds at most one multiply in series.
// A stall on m_tready freezes every stage at once; nothing is dropped or repeated.
// Reset: arst_n clears all stage valid bits asynchronously; the block is ready after release.
module fast_quaternion_slerp_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [151:0]  s_tdata,  // q1_x, q1_y, q1_z, q1_w, q2_x, q2_y, q2_z, q2_w, t_frac, pad
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata   // out_x, out_y, out_z, out_w
);

	logic               en;
	fqs_pkg::pipe_t     p_s2, p_s9;
	fqs_pkg::w_t        sec_s9, vers_s9, r2sh_s9, alpha_s18, beta_s18;
	fqs_pkg::ctx_t      ctx_s18;
	fqs_pkg::c_t [3:0]  out_s22;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tdata  = out_s22;

	fqs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.q1       (s_tdata[63:0]),
		.q2       (s_tdata[127:64]),
		.t_frac   (s_tdata[144:128]),
		.p_s2     (p_s2)
	);

	fqs_secant u_secant (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.p_s2    (p_s2),
		.p_s9    (p_s9),
		.sec_s9  (sec_s9),
		.vers_s9 (vers_s9),
		.r2sh_s9 (r2sh_s9)
	);

	fqs_series u_series (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.p_s9      (p_s9),
		.sec_s9    (sec_s9),
		.vers_s9   (vers_s9),
		.r2sh_s9   (r2sh_s9),
		.ctx_s18   (ctx_s18),
		.alpha_s18 (alpha_s18),
		.beta_s18  (beta_s18)
	);

	fqs_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctx_s18   (ctx_s18),
		.alpha_s18 (alpha_s18),
		.beta_s18  (beta_s18),
		.valid_s22 (m_tvalid),
		.out_s22   (out_s22)
	);

endmodule

### rtl/fqs_chk.sv
module fqs_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [63:0]   m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind fast_quaternion_slerp_top fqs_chk u_fqs_chk (.*);

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int N_RANDOM   = 1550;
	localparam int CYCLE_CAP  = 400000;
	localparam int DRAIN_WAIT = 40;

	typedef struct {
		logic signed [15:0] q [4];
	} quat_t;

	typedef struct {
		logic signed [15:0] a [4];
		logic signed [15:0] b [4];
		logic [16:0]        t;
	} slerp_in_t;

	int errors = 0;
	int cycles = 0;

	task automatic report(input string msg);
		$display("tb: mismatch: %s", msg);
		errors++;
	endtask

	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] sat_w(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] add_w(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat_w(64'(a) + 64'(b));
	endfunction

	function automatic logic signed [31:0] sub_w(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat_w(64'(a) - 64'(b));
	endfunction

	function automatic logic signed [31:0] mul_w(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat_w(rnd_shift(64'(a) * 64'(b), 24));
	endfunction

	function automatic logic signed [31:0] blend_series(input logic signed [31:0] sq,
		input logic signed [31:0] r2, input logic signed [31:0] vers);
		logic signed [31:0] r;
		r = add_w(fqs_pkg::K_S3, mul_w(sub_w(sq, fqs_pkg::K_16), r2));
		r = add_w(fqs_pkg::K_S2, mul_w(mul_w(r, sub_w(sq, fqs_pkg::K_9)), vers));
		r = add_w(fqs_pkg::K_S1, mul_w(mul_w(r, sub_w(sq, fqs_pkg::K_4)), vers));
		return add_w(fqs_pkg::K_ONE, mul_w(mul_w(r, sub_w(sq, fqs_pkg::K_ONE)), vers));
	endfunction

	function automatic quat_t slerp_predict(input slerp_in_t x);
		quat_t r;
		logic [16:0] tf;
		logic same;
		logic signed [63:0] dot, adot, t, f2a, f2b, u, f1, o;
		logic signed [31:0] halfy, sec, vers, r2sh, r1v, r2v, r1, alpha, beta, len, corr;
		logic signed [31:0] v [4];
		tf = x.t > fqs_pkg::T_ONE ? fqs_pkg::T_ONE : x.t;
		same = 1'b1;
		for (int i = 0; i < 4; i++) if (x.a[i] != x.b[i]) same = 1'b0;
		if (tf == 0 || same) begin
			r.q = x.a;
			return r;
		end
		if (tf == fqs_pkg::T_ONE) begin
			r.q = x.b;
			return r;
		end
		dot = 0;
		for (int i = 0; i < 4; i++) dot += 64'(x.a[i]) * 64'(x.b[i]);
		adot = dot >= 0 ? dot : -dot;
		halfy = add_w(fqs_pkg::K_ONE, sat_w(rnd_shift(adot, 4)));
		t = 64'(tf) * 256;
		f2b = t - 64'(fqs_pkg::K_HALF);
		u = f2b >= 0 ? f2b : -f2b;
		f2a = u - f2b;
		f2b = f2b + u;
		u = u + u;
		f1 = 64'(fqs_pkg::K_ONE) - u;
		sec = sub_w(fqs_pkg::K_A0, mul_w(sub_w(fqs_pkg::K_A1, mul_w(fqs_pkg::K_A2, halfy)),
			halfy));
		sec = mul_w(sec, sub_w(fqs_pkg::K_1P5, mul_w(mul_w(halfy, sec), sec)));
		vers = sub_w(fqs_pkg::K_ONE, mul_w(halfy, sec));
		r2sh = mul_w(fqs_pkg::K_S4, vers);
		r1v = blend_series(mul_w(f1[31:0], f1[31:0]), r2sh, vers);
		r2v = blend_series(mul_w(u[31:0], u[31:0]), r2sh, vers);
		r1 = mul_w(f1[31:0], mul_w(r1v, sec));
		alpha = add_w(r1, mul_w(f2a[31:0], r2v));
		if (dot < 0) alpha = sat_w(-64'(alpha));
		beta = add_w(r1, mul_w(f2b[31:0], r2v));
		for (int i = 0; i < 4; i++)
			v[i] = add_w(mul_w(alpha, 32'(x.a[i]) * 1024), mul_w(beta, 32'(x.b[i]) * 1024));
		len = mul_w(v[3], v[3]);
		for (int i = 0; i < 3; i++) len = add_w(len, mul_w(v[i], v[i]));
		corr = sub_w(fqs_pkg::K_1P5, mul_w(fqs_pkg::K_HALF, len));
		for (int i = 0; i < 4; i++) begin
			o = rnd_shift(64'(v[i]) * 64'(corr), 34);
			if (o > 32767) o = 32767;
			if (o < -32768) o = -32768;
			r.q[i] = o[15:0];
		end
		return r;
	endfunction

	class slerp_scoreboard;
		quat_t pending [$];

		function void note_input(input slerp_in_t x);
			pending.push_back(slerp_predict(x));
		endfunction

		task check_result(input logic [63:0] d);
			quat_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected item %h", d));
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < 4; i++)
				if (d[16*i +: 16] !== e.q[i])
					report($sformatf("component %0d got %h want %h", i, d[16*i +: 16], e.q[i]));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [151:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic sending_done = 1'b0;
	logic hold_off = 1'b0;

	slerp_scoreboard sb = new();

	fast_quaternion_slerp_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [151:0] pack_in(input slerp_in_t x);
		logic [151:0] d;
		d = '0;
		for (int i = 0; i < 4; i++) begin
			d[16*i +: 16] = x.a[i];
			d[64 + 16*i +: 16] = x.b[i];
		end
		d[128 +: 17] = x.t;
		return d;
	endfunction

	task automatic send_item(input slerp_in_t x, input logic no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pack_in(x);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(x);
		@(negedge clk);
	endtask

	function automatic slerp_in_t rand_unit_like(input int mode);
		slerp_in_t x;
		for (int i = 0; i < 4; i++) begin
			if (mode == 0) begin
				x.a[i] = 16'($urandom_range(0, 16'hffff));
				x.b[i] = 16'($urandom_range(0, 16'hffff));
			end else begin
				x.a[i] = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
				x.b[i] = x.a[i] + $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
			end
		end
		if ($urandom_range(0, 9) == 0) x.b = x.a;
		case ($urandom_range(0, 19))
			0: x.t = 17'd0;
			1: x.t = fqs_pkg::T_ONE;
			2: x.t = 17'($urandom_range(65537, 131071));
			default: x.t = 17'($urandom_range(1, 65535));
		endcase
		return x;
	endfunction

	task automatic directed();
		slerp_in_t x;
		logic signed [15:0] ext [4];
		ext = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh4000};
		for (int k = 0; k < 20; k++) begin
			for (int i = 0; i < 4; i++) begin
				x.a[i] = ext[(i + k) % 4];
				x.b[i] = ext[(i + 3 * k + 1) % 4];
			end
			case (k % 5)
				0: x.t = 17'd0;
				1: x.t = fqs_pkg::T_ONE;
				2: x.t = 17'h1ffff;
				3: x.t = 17'd32768;
				default: x.t = 17'd1;
			endcase
			if (k == 7) x.b = x.a;
			if (k == 9) begin
				x.a = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384};
				x.b = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384};
				x.t = 17'd16384;
			end
			if (k == 11) begin
				x.a = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
				x.b = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
				x.t = 17'd65535;
			end
			send_item(x, 1'b0);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed();
		for (int n = 0; n < N_RANDOM; n++) begin
			send_item(rand_unit_like($urandom_range(0, 3) == 0 ? 0 : 1),
				hold_off || ($urandom_range(0, 4) == 0));
		end
		s_tvalid <= 1'b0;
		sending_done <= 1'b1;
	end

	initial begin
		int g;
		@(posedge arst_n);
		repeat (300) @(negedge clk);
		hold_off <= 1'b1;
		m_tready <= 1'b0;
		repeat (120) @(negedge clk);
		hold_off <= 1'b0;
		forever begin
			g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	initial begin
		@(posedge sending_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && sb.pending.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("tb: FAIL");
			$finish;
		end
	end

endmodule

### sim.f
rtl/fqs_pkg.sv
rtl/fqs_front.sv
rtl/fqs_secant.sv
rtl/fqs_series.sv
rtl/fqs_combine.sv
rtl/fast_quaternion_slerp_top.sv
rtl/fqs_chk.sv
dv/tb.sv
